FILE: hdl/vbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-byte pair codec package
// Shared constants, codes and types of the variable-byte pair codec.
// ----------------------------------------------------------------------------
package vbp_pkg;

  localparam int DEFAULT_VALUE_BITS = 31;
  localparam int GROUP_BITS = 7;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic KIND_ENC_BYTE = 1'b0;
  localparam logic KIND_DEC_PAIR = 1'b1;

  typedef enum logic [1:0] {
    ENC_IDLE,
    ENC_FIRST,
    ENC_SECOND
  } enc_state_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } enc_beat_t;

endpackage

FILE: hdl/vbp_enc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-byte pair encoder
// Shifts the first and then the second value out seven bits and one coded
// byte per cycle while the output is free; marks the final byte of the pair.
// ----------------------------------------------------------------------------
module vbp_enc #(
  parameter int VALUE_BITS = vbp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value_first,
  input  logic [VALUE_BITS-1:0] value_second,
  input  logic                  out_free,
  output logic                  idle,
  output vbp_pkg::enc_beat_t    beat
);

  vbp_pkg::enc_state_t state, state_next;
  logic [VALUE_BITS-1:0] shreg, shreg_next;
  logic [VALUE_BITS-1:0] held_second, held_second_next;
  logic more;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vbp_pkg::ENC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg       <= shreg_next;
    held_second <= held_second_next;
  end

  always_comb begin
    more             = (shreg >> vbp_pkg::GROUP_BITS) != '0;
    idle             = (state == vbp_pkg::ENC_IDLE);
    beat.valid       = !idle;
    beat.last        = (state == vbp_pkg::ENC_SECOND) && !more;
    beat.data        = {shreg[vbp_pkg::GROUP_BITS-1:0], more};
    advance          = beat.valid && out_free;
    state_next       = state;
    shreg_next       = shreg;
    held_second_next = held_second;
    unique case (state)
      vbp_pkg::ENC_IDLE: begin
        if (start) begin
          shreg_next       = value_first;
          held_second_next = value_second;
          state_next       = vbp_pkg::ENC_FIRST;
        end
      end
      vbp_pkg::ENC_FIRST: begin
        if (advance) begin
          if (more) begin
            shreg_next = shreg >> vbp_pkg::GROUP_BITS;
          end else begin
            shreg_next = held_second;
            state_next = vbp_pkg::ENC_SECOND;
          end
        end
      end
      vbp_pkg::ENC_SECOND: begin
        if (advance) begin
          if (more) begin
            shreg_next = shreg >> vbp_pkg::GROUP_BITS;
          end else begin
            state_next = vbp_pkg::ENC_IDLE;
          end
        end
      end
      default: begin
        state_next = vbp_pkg::ENC_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/vbp_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-byte pair decoder
// Takes one coded byte per cycle into the group accumulator and reports a
// pair when the second value of a pair completes.
// ----------------------------------------------------------------------------
module vbp_dec #(
  parameter int VALUE_BITS = vbp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_stream,
  output logic                  pair_valid,
  output logic [VALUE_BITS-1:0] pair_first,
  output logic [VALUE_BITS-1:0] pair_second,
  output logic                  overflow
);

  localparam int MaxGroups = (VALUE_BITS + vbp_pkg::GROUP_BITS - 1) / vbp_pkg::GROUP_BITS;
  localparam int AccW = MaxGroups * vbp_pkg::GROUP_BITS;
  localparam int PosW = $clog2(MaxGroups + 1);

  logic [AccW-1:0]       accumulator, accumulator_next;
  logic [PosW-1:0]       group_position, group_position_next;
  logic                  second_half, second_half_next;
  logic [VALUE_BITS-1:0] held_first, held_first_next;
  logic                  overflow_seen, overflow_seen_next;
  logic [AccW-1:0]       acc_upd;
  logic                  ovf_upd;
  logic                  more;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      group_position <= '0;
      second_half    <= 1'b0;
      held_first     <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      accumulator    <= accumulator_next;
      group_position <= group_position_next;
      second_half    <= second_half_next;
      held_first     <= held_first_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

  always_comb begin
    more    = in_byte[0];
    acc_upd = accumulator;
    ovf_upd = overflow_seen;
    if (group_position < PosW'(MaxGroups)) begin
      for (int i = 0; i < MaxGroups; i++) begin
        if (group_position == PosW'(i)) begin
          acc_upd[i*vbp_pkg::GROUP_BITS +: vbp_pkg::GROUP_BITS] = in_byte[7:1];
        end
      end
    end else begin
      ovf_upd = 1'b1;
    end

    accumulator_next    = accumulator;
    group_position_next = group_position;
    second_half_next    = second_half;
    held_first_next     = held_first;
    overflow_seen_next  = overflow_seen;
    pair_valid          = 1'b0;
    pair_first          = held_first;
    pair_second         = acc_upd[VALUE_BITS-1:0];
    overflow            = ovf_upd;

    if (byte_valid) begin
      accumulator_next   = acc_upd;
      overflow_seen_next = ovf_upd;
      if (group_position < PosW'(MaxGroups)) begin
        group_position_next = group_position + PosW'(1);
      end
      if (!more) begin
        accumulator_next    = '0;
        group_position_next = '0;
        if (!second_half) begin
          held_first_next  = acc_upd[VALUE_BITS-1:0];
          second_half_next = 1'b1;
        end else begin
          pair_valid         = 1'b1;
          second_half_next   = 1'b0;
          held_first_next    = '0;
          overflow_seen_next = 1'b0;
        end
      end
      if (end_of_stream) begin
        accumulator_next    = '0;
        group_position_next = '0;
        second_half_next    = 1'b0;
        held_first_next     = '0;
        overflow_seen_next  = 1'b0;
      end
    end
  end

endmodule

FILE: hdl/varbyte_pair_codec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-byte pair codec
// Encodes pairs of non-negative integers into variable-byte codes and
// decodes such codes back into pairs.
// ----------------------------------------------------------------------------
// An encode request loads a shift register that moves seven bits per cycle and
// gives one coded byte per cycle while the result side is free. The encoder
// gives out the bytes of the first value and then of the second, and the
// unit takes no new item until the encoder has given out the last byte of the
// pair. A decode request feeds one byte to the decoder, which yields a pair
// beat when the second value completes. An output register separates the two
// sides, and a new item is taken only while the encoder is idle and that
// register is empty or drains in the same cycle.
module varbyte_pair_codec_unit #(
  parameter int VALUE_BITS = vbp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // value_first, value_second, in_byte
  input  logic [((2*VALUE_BITS+8+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  logic s_axis_tuser,
  // end_of_stream
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_byte, pair_first, pair_second, overflow
  output logic [((2*VALUE_BITS+9+7)/8)*8-1:0] m_axis_tdata,
  // out_kind
  output logic m_axis_tuser,
  // last_of_pair
  output logic m_axis_tlast
);

  localparam int OutW = ((2 * VALUE_BITS + 9 + 7) / 8) * 8;

  logic                  in_accept;
  logic                  out_free;
  logic                  enc_idle;
  vbp_pkg::enc_beat_t    enc_beat;
  logic                  dec_valid;
  logic [VALUE_BITS-1:0] dec_first;
  logic [VALUE_BITS-1:0] dec_second;
  logic                  dec_overflow;

  logic                  out_valid;
  logic                  out_kind;
  logic [7:0]            out_byte;
  logic                  out_last;
  logic [VALUE_BITS-1:0] out_first;
  logic [VALUE_BITS-1:0] out_second;
  logic                  out_overflow;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = enc_idle && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  vbp_enc #(.VALUE_BITS(VALUE_BITS)) u_enc (
    .clk          (clk),
    .rst          (rst),
    .start        (in_accept && (s_axis_tuser == vbp_pkg::REQ_ENCODE)),
    .value_first  (s_axis_tdata[VALUE_BITS-1:0]),
    .value_second (s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .out_free     (out_free),
    .idle         (enc_idle),
    .beat         (enc_beat)
  );

  vbp_dec #(.VALUE_BITS(VALUE_BITS)) u_dec (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (in_accept && (s_axis_tuser == vbp_pkg::REQ_DECODE)),
    .in_byte       (s_axis_tdata[2*VALUE_BITS+7:2*VALUE_BITS]),
    .end_of_stream (s_axis_tlast),
    .pair_valid    (dec_valid),
    .pair_first    (dec_first),
    .pair_second   (dec_second),
    .overflow      (dec_overflow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enc_beat.valid && out_free) begin
      out_valid <= 1'b1;
    end else if (dec_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_beat.valid && out_free) begin
      out_kind     <= vbp_pkg::KIND_ENC_BYTE;
      out_byte     <= enc_beat.data;
      out_last     <= enc_beat.last;
      out_first    <= '0;
      out_second   <= '0;
      out_overflow <= 1'b0;
    end else if (dec_valid) begin
      out_kind     <= vbp_pkg::KIND_DEC_PAIR;
      out_byte     <= '0;
      out_last     <= 1'b0;
      out_first    <= dec_first;
      out_second   <= dec_second;
      out_overflow <= dec_overflow;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = OutW'({out_overflow, out_second, out_first, out_byte});

endmodule

FILE: hdl/vbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-byte pair codec checker
// Port-level checks of the codec's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module vbp_checker #(
  parameter int VALUE_BITS = vbp_pkg::DEFAULT_VALUE_BITS
) (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((2*VALUE_BITS+9+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tuser,
  input logic m_axis_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == vbp_pkg::KIND_ENC_BYTE)
      |-> m_axis_tdata[2*VALUE_BITS+8:8] == '0)
    else $error("encoded byte beat carries pair fields");

  a_pair_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == vbp_pkg::KIND_DEC_PAIR)
      |-> !m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
    else $error("decoded pair beat carries byte fields");

  a_last_no_more: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == vbp_pkg::KIND_ENC_BYTE) && m_axis_tlast
      |-> !m_axis_tdata[0])
    else $error("final byte of a pair has its continuation bit set");

endmodule

bind varbyte_pair_codec_unit vbp_checker #(.VALUE_BITS(VALUE_BITS)) u_vbp_checker (.*);

FILE: tb/varbyte_pair_codec_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-byte pair codec testbench
// Drives encode and decode beats into the codec with random idle bursts on
// both stream sides. A scoreboard predicts every coded byte and decoded pair,
// including overflow, dropped high bits and end-of-stream clearing. It checks
// each output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module varbyte_pair_codec_unit_tb;

  localparam int VB = vbp_pkg::DEFAULT_VALUE_BITS;
  localparam int IN_W = ((2 * VB + 8 + 7) / 8) * 8;
  localparam int OUT_W = ((2 * VB + 9 + 7) / 8) * 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_END = 200;
  localparam int CALM_FROM = 170;
  localparam int PAUSE_AT = 100;

  typedef struct packed {
    logic          req;
    logic [VB-1:0] first;
    logic [VB-1:0] second;
    logic [7:0]    in_byte;
    logic          eos;
  } codec_req_t;

  typedef struct packed {
    logic          kind;
    logic [7:0]    code_byte;
    logic          last;
    logic [VB-1:0] first;
    logic [VB-1:0] second;
    logic          ovf;
  } codec_beat_t;

  class codec_scoreboard;
    localparam int MAX_GROUPS = (VB + 6) / 7;

    codec_beat_t expected_beats[$];
    logic [VB-1:0] acc;
    int unsigned groups;
    bit second_half;
    logic [VB-1:0] held_first;
    bit ovf_seen;
    int errors;

    function new();
      errors = 0;
      clear_decoder();
    endfunction

    function void clear_decoder();
      acc = '0;
      groups = 0;
      second_half = 1'b0;
      held_first = '0;
      ovf_seen = 1'b0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void expect_beat(codec_beat_t b);
      expected_beats = {expected_beats, b};
    endfunction

    function void push_coded_value(logic [VB-1:0] v, bit final_value);
      logic [VB-1:0] rest;
      codec_beat_t b;
      bit more;
      rest = v;
      do begin
        b = '0;
        b.kind = vbp_pkg::KIND_ENC_BYTE;
        more = (rest >> 7) != 0;
        b.code_byte = {rest[6:0], more};
        b.last = final_value && !more;
        expect_beat(b);
        rest = rest >> 7;
      end while (more);
    endfunction

    function void note_request(codec_req_t r);
      logic [6:0] grp;
      codec_beat_t b;
      if (r.req == vbp_pkg::REQ_ENCODE) begin
        push_coded_value(r.first, 1'b0);
        push_coded_value(r.second, 1'b1);
      end else begin
        grp = r.in_byte[7:1];
        if (groups < MAX_GROUPS) begin
          acc = acc | VB'({57'd0, grp} << (7 * groups));
          groups++;
        end else begin
          ovf_seen = 1'b1;
        end
        if (!r.in_byte[0]) begin
          if (!second_half) begin
            held_first = acc;
            second_half = 1'b1;
            acc = '0;
            groups = 0;
          end else begin
            b = '0;
            b.kind = vbp_pkg::KIND_DEC_PAIR;
            b.first = held_first;
            b.second = acc;
            b.ovf = ovf_seen;
            expect_beat(b);
            clear_decoder();
          end
        end
        if (r.eos)
          clear_decoder();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50)
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_beat(codec_beat_t got);
      codec_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d byte=%02h pair=%0d,%0d",
                         got.kind, got.code_byte, got.first, got.second));
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.code_byte !== want.code_byte)
          report($sformatf("byte %02h, expected %02h", got.code_byte, want.code_byte));
        if (got.last !== want.last)
          report($sformatf("last_of_pair %0d, expected %0d", got.last, want.last));
        if (got.first !== want.first)
          report($sformatf("pair_first %0d, expected %0d", got.first, want.first));
        if (got.second !== want.second)
          report($sformatf("pair_second %0d, expected %0d", got.second, want.second));
        if (got.ovf !== want.ovf)
          report($sformatf("overflow %0d, expected %0d", got.ovf, want.ovf));
      end
    endtask

    task check_drained();
      if (expected_beats.size() != 0)
        report($sformatf("%0d expected beats never arrived", expected_beats.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  codec_scoreboard sb = new();
  bit calm = 1'b0;
  int n_items = 0;
  int unsigned cycles = 0;

  varbyte_pair_codec_unit #(.VALUE_BITS(VB)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    codec_req_t r;
    codec_beat_t b;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      r.req = s_axis_tuser;
      r.first = s_axis_tdata[VB-1:0];
      r.second = s_axis_tdata[2*VB-1:VB];
      r.in_byte = s_axis_tdata[2*VB+7:2*VB];
      r.eos = s_axis_tlast;
      sb.note_request(r);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      b.kind = m_axis_tuser;
      b.last = m_axis_tlast;
      b.code_byte = m_axis_tdata[7:0];
      b.first = m_axis_tdata[VB+7:8];
      b.second = m_axis_tdata[2*VB+7:VB+8];
      b.ovf = m_axis_tdata[2*VB+8];
      sb.check_beat(b);
    end
  end

  function automatic logic [VB-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return VB'($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  task automatic send_item(codec_req_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.req;
    s_axis_tlast <= r.eos;
    s_axis_tdata <= IN_W'({r.in_byte, r.second, r.first});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic encode_pair(logic [VB-1:0] a, logic [VB-1:0] b, logic eos);
    codec_req_t r;
    r.req = vbp_pkg::REQ_ENCODE;
    r.first = a;
    r.second = b;
    r.in_byte = 8'($urandom);
    r.eos = eos;
    send_item(r);
  endtask

  task automatic decode_byte(logic [7:0] code, logic eos);
    codec_req_t r;
    r.req = vbp_pkg::REQ_DECODE;
    r.first = VB'($urandom);
    r.second = VB'($urandom);
    r.in_byte = code;
    r.eos = eos;
    send_item(r);
  endtask

  // Extra random groups after the natural ones lengthen the code, and past
  // five groups the value overflows.
  task automatic decode_value(logic [VB-1:0] v, int pad, bit eos_last, bit mix);
    logic [7:0] q[$];
    logic [VB-1:0] rest;
    rest = v;
    do begin
      q = {q, {rest[6:0], 1'b1}};
      rest = rest >> 7;
    end while (rest != 0);
    repeat (pad) q = {q, {7'($urandom), 1'b1}};
    q[q.size()-1][0] = 1'b0;
    foreach (q[i]) begin
      if (mix && $urandom_range(0, 9) == 0)
        encode_pair(rand_value(), rand_value(), 1'($urandom));
      decode_byte(q[i], eos_last && i == q.size() - 1);
    end
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit paused;
    int pad_a;
    int pad_b;
    paused = 1'b0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    fork
      forever begin
        if (!calm && $urandom_range(0, 2) == 0) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    join_none

    encode_pair('0, '0, 1'b0);
    encode_pair('1, '1, 1'b1);
    encode_pair(VB'(127), VB'(128), 1'b0);
    encode_pair(VB'(1), VB'(1) << 28, 1'b0);
    decode_byte(8'h00, 1'b0);
    decode_byte(8'h00, 1'b0);
    // The largest first value, then a second value of six groups whose fifth
    // group carries bits above the value width, with an encode in between.
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'hFF, 1'b0);
    encode_pair(VB'(300), VB'(5), 1'b1);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'h0E, 1'b0);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'h02, 1'b0);
    // End of stream inside a pair drops it.
    decode_byte(8'h05, 1'b0);
    decode_byte(8'h02, 1'b1);
    decode_byte(8'h00, 1'b0);
    decode_byte(8'h00, 1'b1);

    while (n_items < RANDOM_END) begin
      if (n_items >= CALM_FROM)
        calm = 1'b1;
      if (!paused && n_items >= PAUSE_AT) begin
        drain_wait();
        paused = 1'b1;
      end
      pad_a = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      pad_b = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          encode_pair(rand_value(), rand_value(), 1'($urandom));
        end
        16, 17: begin
          decode_value(rand_value(), pad_a, 1'b0, 1'b0);
          decode_byte(8'($urandom), 1'b1);
        end
        18, 19: begin
          decode_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        default: begin
          decode_value(rand_value(), pad_a, 1'b0, 1'b1);
          decode_value(rand_value(), pad_b, $urandom_range(0, 7) == 0, 1'b1);
        end
      endcase
    end

    drain_wait();
    repeat (20) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
